>>> sv/sorted_priority_queue_assert.svh
// Assertion macros for the sorted priority queue.
// Included by the top level; depends on nothing else.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue: next-cycle check failed");

`endif

>>> sv/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
// No dependencies; used by the interfaces, the cell and the top level.
package spq_pkg;

    localparam int DEPTH       = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int VALUE_W     = 32;
    localparam int PRIO_W      = 8;
    localparam int OUT_CNT_W   = 5;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // Contents of one storage cell.
    typedef struct packed {
        logic                       used;
        logic        [PRIO_W-1:0]   prio;
        logic signed [VALUE_W-1:0]  value;
    } t_slot;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        t_mode                      mode;
        logic                       ins_en;
        logic                       rem_en;
        logic        [PRIO_W-1:0]   prio;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_cmd;

endpackage

>>> sv/spq_if.sv
// Valid/ready channel interfaces of the sorted priority queue.
// Depends on spq_pkg.
interface spq_in_if;
    logic                               valid;
    logic                               ready;
    spq_pkg::t_mode                     mode;
    logic signed [spq_pkg::VALUE_W-1:0] value;
    logic        [spq_pkg::PRIO_W-1:0]  prio;

    modport source (output valid, output mode, output value, output prio, input ready);
    modport sink   (input valid, input mode, input value, input prio, output ready);
endinterface

interface spq_out_if;
    logic                                 valid;
    logic                                 ready;
    spq_pkg::t_status                     status;
    logic signed [spq_pkg::VALUE_W-1:0]   removed_value;
    logic        [spq_pkg::PRIO_W-1:0]    removed_prio;
    logic        [spq_pkg::OUT_CNT_W-1:0] entry_count;
    logic                                 is_empty;

    modport source (output valid, output status, output removed_value, output removed_prio,
                    output entry_count, output is_empty, input ready);
    modport sink   (input valid, input status, input removed_value, input removed_prio,
                    input entry_count, input is_empty, output ready);
endinterface

>>> sv/spq_cell.sv
// One storage cell of the sorted chain: holds an entry and trades with its neighbors.
// Depends on spq_pkg.
module spq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  spq_pkg::t_slot     i_left,
    input  logic               i_left_keep,
    input  spq_pkg::t_slot     i_right,
    output spq_pkg::t_slot     o_slot,
    output logic               o_keep,
    output logic               o_hit
);

    spq_pkg::t_slot r_slot;
    spq_pkg::t_slot n_slot;

    // A cell keeps its entry when the entry's priority is below the command's priority, or equal to it on an insert.
    always_comb begin
        if (i_cmd.mode == spq_pkg::MODE_INSERT) begin
            o_keep = r_slot.used && (r_slot.prio <= i_cmd.prio);
        end else begin
            o_keep = r_slot.used && (r_slot.prio < i_cmd.prio);
        end
    end

    // First used cell that is not kept is the one a remove takes out.
    assign o_hit = r_slot.used && !o_keep && i_left_keep;

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.ins_en && !o_keep) begin
            if (i_left_keep) begin
                n_slot.used  = 1'b1;
                n_slot.prio  = i_cmd.prio;
                n_slot.value = i_cmd.value;
            end else begin
                n_slot = i_left;
            end
        end else if (i_cmd.rem_en && !o_keep) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.used <= 1'b0;
        end else begin
            r_slot.used <= n_slot.used;
        end
        r_slot.prio  <= n_slot.prio;
        r_slot.value <= n_slot.value;
    end

    assign o_slot = r_slot;

endmodule

>>> sv/sorted_priority_queue.sv
// Sorted priority queue: a chain of DEPTH cells kept in ascending priority order.
// Throughput: one item per cycle unless stalled; every cell compares and shifts on accept.
// The result is registered and offered in the cycle after the item's transfer.
// The input is taken whenever the output register is empty or is being drained.
// Reset (synchronous, active low) marks every cell unused and clears the count and
// the output valid; entry payloads are not reset.
module sorted_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spq_in_if.sink      i_in,
    spq_out_if.source   o_out
);

    localparam int DEPTH = spq_pkg::DEPTH;

    // Chain wiring: slot contents, keep flags and hit flags of every cell.
    spq_pkg::t_slot            w_slot [DEPTH];
    logic          [DEPTH-1:0] w_keep;
    logic          [DEPTH-1:0] w_hit;
    logic          [DEPTH-1:0] w_used;
    spq_pkg::t_cell_cmd        w_cmd;

    logic                        w_accept;
    logic                        w_full;
    logic                        w_found;
    spq_pkg::t_slot              w_removed;

    logic [spq_pkg::CNT_W-1:0]   r_count;
    logic [spq_pkg::CNT_W-1:0]   n_count;

    logic                                 r_out_valid;
    spq_pkg::t_status                     r_status;
    spq_pkg::t_status                     n_status;
    logic signed [spq_pkg::VALUE_W-1:0]   r_removed_value;
    logic        [spq_pkg::PRIO_W-1:0]    r_removed_prio;
    logic        [spq_pkg::OUT_CNT_W-1:0] r_entry_count;
    logic                                 r_is_empty;

    // A new item may enter whenever the result register is free or drains this cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // The used cells always form a packed prefix, so the last cell tells us the store is full.
    assign w_full = w_slot[DEPTH-1].used;

    // At most one cell can hit on a remove; OR the masked slots to pick it out.
    always_comb begin
        w_removed = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_removed = w_removed | (w_hit[k] ? w_slot[k] : '0);
        end
    end
    assign w_found = |w_hit;

    // Command to the chain. The compare mode is always driven so that the keep
    // and hit flags are valid in the cycle the item is offered.
    always_comb begin
        w_cmd.mode   = i_in.mode;
        w_cmd.prio   = i_in.prio;
        w_cmd.value  = i_in.value;
        w_cmd.ins_en = w_accept && (i_in.mode == spq_pkg::MODE_INSERT) && !w_full;
        w_cmd.rem_en = w_accept && (i_in.mode == spq_pkg::MODE_REMOVE) && w_found;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            spq_pkg::t_slot w_left;
            spq_pkg::t_slot w_right;
            logic           w_left_keep;

            if (g == 0) begin : g_head
                // The head has no left neighbor; it behaves as if everything ahead is kept.
                assign w_left      = '0;
                assign w_left_keep = 1'b1;
            end else begin : g_body
                assign w_left      = w_slot[g-1];
                assign w_left_keep = w_keep[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                // The tail pulls in an empty slot when the chain shifts toward the head.
                assign w_right = '0;
            end else begin : g_mid
                assign w_right = w_slot[g+1];
            end

            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_left      (w_left),
                .i_left_keep (w_left_keep),
                .i_right     (w_right),
                .o_slot      (w_slot[g]),
                .o_keep      (w_keep[g]),
                .o_hit       (w_hit[g])
            );

            assign w_used[g] = w_slot[g].used;
        end
    endgenerate

    // Fill count and status of the item being accepted.
    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_OK;
        if (i_in.mode == spq_pkg::MODE_INSERT) begin
            if (w_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + spq_pkg::CNT_W'(1);
            end
        end else begin
            if (!w_found) begin
                n_status = spq_pkg::ST_NOT_FOUND;
            end else begin
                n_count = r_count - spq_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; only a successful remove reports the entry taken out.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= n_status;
            r_entry_count <= spq_pkg::OUT_CNT_W'(n_count);
            r_is_empty    <= (n_count == '0);
            if ((i_in.mode == spq_pkg::MODE_REMOVE) && w_found) begin
                r_removed_value <= w_removed.value;
                r_removed_prio  <= w_removed.prio;
            end else begin
                r_removed_value <= '0;
                r_removed_prio  <= '0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.removed_value = r_removed_value;
    assign o_out.removed_prio  = r_removed_prio;
    assign o_out.entry_count   = r_entry_count;
    assign o_out.is_empty      = r_is_empty;

`include "sorted_priority_queue_assert.svh"

    // The count register tracks the number of used cells.
    `SPQ_ASSERT_IMPL(a_count_matches, i_clk, i_rst_n, 1'b1, r_count == $countones(w_used))
    // Used cells form a packed prefix starting at the head.
    `SPQ_ASSERT_IMPL(a_used_prefix, i_clk, i_rst_n, 1'b1, (w_used & (w_used + 1'b1)) == '0)
    // A remove can never select more than one cell.
    `SPQ_ASSERT_IMPL(a_single_hit, i_clk, i_rst_n, w_cmd.rem_en, $onehot(w_hit))
    // An insert into a store with room grows the count by one.
    `SPQ_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_cmd.ins_en,
                     r_count == $past(r_count) + 1'b1)

endmodule
